// ===== design/qai_pkg.sv =====
// ----------------------------------------------------------------------------
// qai_pkg
// Shared types and constants of the quaternion attitude integrator.
// ----------------------------------------------------------------------------
package qai_pkg;

  localparam int unsigned NUM_COMP    = 4;
  localparam int unsigned NUM_RATE    = 3;
  localparam int unsigned NUM_PROD    = 12;
  localparam int unsigned STEP_SHIFT  = 53;

  localparam logic [31:0] TIME_STEP_RESET = 32'd4294967;

  localparam logic signed [44:0] SUM_LIMIT = 45'sd2147483647;
  localparam logic signed [44:0] SUM_FLOOR = -45'sd2147483647;

  localparam int unsigned STEP_STAGES = 4;
  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned NORM_STAGES = SQRT_STAGES + 2;
  localparam int unsigned QUO_STAGES  = 16;
  localparam int unsigned DIV_STAGES  = QUO_STAGES + 1;
  localparam int unsigned PIPE_STAGES = STEP_STAGES + NORM_STAGES + DIV_STAGES;

  typedef logic signed [31:0] comp_t;
  typedef logic [31:0]        root_t;

endpackage

// ===== design/qai_in_if.sv =====
// ----------------------------------------------------------------------------
// qai_in_if
// Input channel: attitude quaternion and body rates.
// ----------------------------------------------------------------------------
interface qai_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] att_w;
  logic signed [31:0] att_x;
  logic signed [31:0] att_y;
  logic signed [31:0] att_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (output valid, att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

// ===== design/qai_out_if.sv =====
// ----------------------------------------------------------------------------
// qai_out_if
// Output channel: normalized updated quaternion and zero norm flag.
// ----------------------------------------------------------------------------
interface qai_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_w;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic               zero_norm;

  modport source (output valid, new_w, new_x, new_y, new_z, zero_norm, input ready);
  modport sink (input valid, new_w, new_x, new_y, new_z, zero_norm, output ready);
endinterface

// ===== design/qai_step.sv =====
// ----------------------------------------------------------------------------
// qai_step
// Euler step: Hamilton product terms, scaling by the time step, rounding,
// addition to the attitude and saturation. Four register stages.
// ----------------------------------------------------------------------------
module qai_step
  import qai_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] time_step_i,
  input  comp_t       att_i  [NUM_COMP],
  input  comp_t       rate_i [NUM_RATE],
  output comp_t       sum_o  [NUM_COMP]
);

  localparam logic [1:0] AttSel  [NUM_PROD] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3,
                                                2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] RateSel [NUM_PROD] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1,
                                                2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic       NegSel  [NUM_PROD] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                                1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  logic signed [63:0] prod_d [NUM_PROD];
  logic signed [63:0] prod_q [NUM_PROD];
  comp_t              att1_q [NUM_COMP];
  logic [63:0]        mag2_d [NUM_COMP];
  logic [63:0]        mag2_q [NUM_COMP];
  logic               neg2_d [NUM_COMP];
  logic               neg2_q [NUM_COMP];
  comp_t              att2_q [NUM_COMP];
  logic [63:0]        plo_q  [NUM_COMP];
  logic [63:0]        phi_q  [NUM_COMP];
  logic               neg3_q [NUM_COMP];
  comp_t              att3_q [NUM_COMP];
  comp_t              sum_d  [NUM_COMP];
  comp_t              sum_q  [NUM_COMP];

  always_comb begin
    for (int i = 0; i < NUM_PROD; i++) begin
      prod_d[i] = att_i[AttSel[i]] * rate_i[RateSel[i]];
    end
  end

  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] term;
    logic        [65:0] absv;
    for (int j = 0; j < NUM_COMP; j++) begin
      acc = '0;
      for (int t = 0; t < NUM_RATE; t++) begin
        term = {{2{prod_q[3*j+t][63]}}, prod_q[3*j+t]};
        acc  = NegSel[3*j+t] ? acc - term : acc + term;
      end
      absv      = acc[65] ? 66'(-acc) : 66'(acc);
      neg2_d[j] = acc[65];
      mag2_d[j] = absv[63:0];
    end
  end

  always_comb begin
    logic [95:0]        psum;
    logic [42:0]        smag;
    logic signed [44:0] sstep;
    logic signed [44:0] acc;
    for (int j = 0; j < NUM_COMP; j++) begin
      psum  = {32'd0, plo_q[j]} + {phi_q[j], 32'd0} + (96'd1 << (STEP_SHIFT - 1));
      smag  = psum[95:STEP_SHIFT];
      sstep = $signed({2'b00, smag});
      acc   = {{13{att3_q[j][31]}}, att3_q[j]} + (neg3_q[j] ? -sstep : sstep);
      if (acc > SUM_LIMIT) begin
        sum_d[j] = SUM_LIMIT[31:0];
      end else if (acc < SUM_FLOOR) begin
        sum_d[j] = SUM_FLOOR[31:0];
      end else begin
        sum_d[j] = acc[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      att1_q <= att_i;
      mag2_q <= mag2_d;
      neg2_q <= neg2_d;
      att2_q <= att1_q;
      for (int j = 0; j < NUM_COMP; j++) begin
        plo_q[j] <= {32'd0, mag2_q[j][31:0]} * {32'd0, time_step_i};
        phi_q[j] <= {32'd0, mag2_q[j][63:32]} * {32'd0, time_step_i};
      end
      neg3_q <= neg2_q;
      att3_q <= att2_q;
      sum_q  <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== design/qai_norm.sv =====
// ----------------------------------------------------------------------------
// qai_norm
// Squared norm of the updated quaternion and its integer square root,
// two root bits per register stage.
// ----------------------------------------------------------------------------
module qai_norm
  import qai_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  comp_t v_i [NUM_COMP],
  output comp_t v_o [NUM_COMP],
  output root_t root_o,
  output logic  zero_o
);

  logic [63:0] sq_q   [NUM_COMP];
  comp_t       v0_q   [NUM_COMP];
  logic [63:0] n_q;
  logic        zero1_q;
  comp_t       v1_q   [NUM_COMP];

  logic [33:0] rem_q  [SQRT_STAGES];
  root_t       root_q [SQRT_STAGES];
  logic [63:0] nsh_q  [SQRT_STAGES];
  logic        zero_q [SQRT_STAGES];
  comp_t       vs_q   [SQRT_STAGES][NUM_COMP];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        sq_q[j] <= 64'(v_i[j] * v_i[j]);
      end
      v0_q    <= v_i;
      n_q     <= sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
      zero1_q <= (sq_q[0] | sq_q[1] | sq_q[2] | sq_q[3]) == 64'd0;
      v1_q    <= v0_q;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [33:0] rem_in;
    root_t       root_in;
    logic [63:0] nsh_in;
    logic        zero_in;
    comp_t       vs_in [NUM_COMP];
    logic [33:0] rem_d;
    root_t       root_d;
    logic [63:0] nsh_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign nsh_in  = n_q;
      assign zero_in = zero1_q;
      assign vs_in   = v1_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign nsh_in  = nsh_q[k-1];
      assign zero_in = zero_q[k-1];
      assign vs_in   = vs_q[k-1];
    end

    always_comb begin
      logic [34:0] part;
      logic [34:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      nsh_d  = nsh_in;
      for (int s = 0; s < 2; s++) begin
        part  = {rem_d[32:0], nsh_d[63:62]};
        trial = {1'b0, root_d, 2'b01};
        if (part >= trial) begin
          rem_d  = 34'(part - trial);
          root_d = {root_d[30:0], 1'b1};
        end else begin
          rem_d  = part[33:0];
          root_d = {root_d[30:0], 1'b0};
        end
        nsh_d = {nsh_d[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        nsh_q[k]  <= nsh_d;
        zero_q[k] <= zero_in;
        vs_q[k]   <= vs_in;
      end
    end
  end

  assign v_o    = vs_q[SQRT_STAGES-1];
  assign root_o = root_q[SQRT_STAGES-1];
  assign zero_o = zero_q[SQRT_STAGES-1];

endmodule

// ===== design/qai_div.sv =====
// ----------------------------------------------------------------------------
// qai_div
// Divides each component by the root with rounding, two quotient bits per
// register stage, then applies sign, limit and the zero norm case.
// ----------------------------------------------------------------------------
module qai_div
  import qai_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  comp_t v_i [NUM_COMP],
  input  root_t root_i,
  input  logic  zero_i,
  output comp_t new_o [NUM_COMP],
  output logic  zero_o
);

  localparam logic [31:0] OneQ = 32'd1 << QUAT_FRAC_BITS;

  logic [31:0] rem_q  [QUO_STAGES][NUM_COMP];
  logic [31:0] quo_q  [QUO_STAGES][NUM_COMP];
  logic [31:0] nsh_q  [QUO_STAGES][NUM_COMP];
  logic        neg_q  [QUO_STAGES][NUM_COMP];
  root_t       root_q [QUO_STAGES];
  logic        zero_q [QUO_STAGES];
  comp_t       new_d  [NUM_COMP];
  comp_t       new_q  [NUM_COMP];
  logic        zero_out_q;

  for (genvar k = 0; k < QUO_STAGES; k++) begin : g_div
    logic [31:0] rem_in  [NUM_COMP];
    logic [31:0] quo_in  [NUM_COMP];
    logic [31:0] nsh_in  [NUM_COMP];
    logic        neg_in  [NUM_COMP];
    root_t       root_in;
    logic        zero_in;
    logic [31:0] rem_d   [NUM_COMP];
    logic [31:0] quo_d   [NUM_COMP];
    logic [31:0] nsh_d   [NUM_COMP];

    if (k == 0) begin : g_first
      always_comb begin
        logic [31:0] mag;
        logic [63:0] num;
        for (int j = 0; j < NUM_COMP; j++) begin
          mag       = v_i[j][31] ? 32'(-v_i[j]) : 32'(v_i[j]);
          num       = ({32'd0, mag} << QUAT_FRAC_BITS) + {33'd0, root_i[31:1]};
          rem_in[j] = num[63:32];
          nsh_in[j] = num[31:0];
          quo_in[j] = '0;
          neg_in[j] = v_i[j][31];
        end
      end
      assign root_in = root_i;
      assign zero_in = zero_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign nsh_in  = nsh_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign root_in = root_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    always_comb begin
      logic [32:0] part;
      for (int j = 0; j < NUM_COMP; j++) begin
        rem_d[j] = rem_in[j];
        quo_d[j] = quo_in[j];
        nsh_d[j] = nsh_in[j];
        for (int s = 0; s < 2; s++) begin
          part = {rem_d[j], nsh_d[j][31]};
          if (part >= {1'b0, root_in}) begin
            rem_d[j] = 32'(part - {1'b0, root_in});
            quo_d[j] = {quo_d[j][30:0], 1'b1};
          end else begin
            rem_d[j] = part[31:0];
            quo_d[j] = {quo_d[j][30:0], 1'b0};
          end
          nsh_d[j] = {nsh_d[j][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        nsh_q[k]  <= nsh_d;
        neg_q[k]  <= neg_in;
        root_q[k] <= root_in;
        zero_q[k] <= zero_in;
      end
    end
  end

  always_comb begin
    logic [31:0] lim;
    for (int j = 0; j < NUM_COMP; j++) begin
      lim = (quo_q[QUO_STAGES-1][j] > OneQ) ? OneQ : quo_q[QUO_STAGES-1][j];
      if (zero_q[QUO_STAGES-1]) begin
        new_d[j] = '0;
      end else if (neg_q[QUO_STAGES-1][j]) begin
        new_d[j] = -$signed(lim);
      end else begin
        new_d[j] = $signed(lim);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      new_q      <= new_d;
      zero_out_q <= zero_q[QUO_STAGES-1];
    end
  end

  assign new_o  = new_q;
  assign zero_o = zero_out_q;

endmodule

// ===== design/quaternion_attitude_integrator_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_attitude_integrator_core
// Advances an attitude quaternion by one Euler step of the body rates and
// normalizes the result to unit length.
// ----------------------------------------------------------------------------
// Usage:
// A word on att_if carries the attitude quaternion and the body rates; it is
// taken at a clock edge with valid and ready both high. Each input word gives
// exactly one word on res_if with the normalized quaternion and the zero norm
// flag, in input order.
// The time step register is written through cfg_we_i and cfg_data_i. The
// user must write it only while the block is idle; the block does not
// enforce it. Reset loads a step of about one millisecond. The pipeline has
// 39 register stages and takes a new word in every cycle the output is not
// stalled; the root and division run two bits per stage, setting the depth.
// When the receiver holds ready low while a result is shown, the whole
// pipeline holds and att_if.ready goes low in the same cycle; no word is
// lost or repeated. Reset clears all valid bits, so the pipeline comes up
// empty and ready.
// ----------------------------------------------------------------------------
module quaternion_attitude_integrator_core
  import qai_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  qai_in_if.sink      att_if,
  qai_out_if.source   res_if
);

  logic [31:0]            time_step_q;
  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] vld_d;
  logic                   adv;

  comp_t att   [NUM_COMP];
  comp_t rate  [NUM_RATE];
  comp_t sum   [NUM_COMP];
  comp_t nv    [NUM_COMP];
  root_t root;
  logic  nzero;
  comp_t res   [NUM_COMP];
  logic  rzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RESET;
    end else if (cfg_we_i) begin
      time_step_q <= cfg_data_i;
    end
  end

  assign adv   = ~vld_q[PIPE_STAGES-1] | res_if.ready;
  assign vld_d = {vld_q[PIPE_STAGES-2:0], att_if.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign att_if.ready = adv;

  assign att[0]  = att_if.att_w;
  assign att[1]  = att_if.att_x;
  assign att[2]  = att_if.att_y;
  assign att[3]  = att_if.att_z;
  assign rate[0] = att_if.rate_x;
  assign rate[1] = att_if.rate_y;
  assign rate[2] = att_if.rate_z;

  qai_step u_step (
    .clk_i       (clk_i),
    .en_i        (adv),
    .time_step_i (time_step_q),
    .att_i       (att),
    .rate_i      (rate),
    .sum_o       (sum)
  );

  qai_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    (sum),
    .v_o    (nv),
    .root_o (root),
    .zero_o (nzero)
  );

  qai_div #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    (nv),
    .root_i (root),
    .zero_i (nzero),
    .new_o  (res),
    .zero_o (rzero)
  );

  assign res_if.valid     = vld_q[PIPE_STAGES-1];
  assign res_if.new_w     = res[0];
  assign res_if.new_x     = res[1];
  assign res_if.new_y     = res[2];
  assign res_if.new_z     = res[3];
  assign res_if.zero_norm = rzero;

`ifndef SYNTHESIS
  localparam logic signed [31:0] OneS = $signed(32'd1 << QUAT_FRAC_BITS);

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && res_if.zero_norm) |->
      (res_if.new_w == 0 && res_if.new_x == 0 && res_if.new_y == 0 && res_if.new_z == 0))
    else $error("zero norm result with nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid |-> (res_if.new_w <= OneS && res_if.new_w >= -OneS &&
                      res_if.new_x <= OneS && res_if.new_x >= -OneS &&
                      res_if.new_y <= OneS && res_if.new_y >= -OneS &&
                      res_if.new_z <= OneS && res_if.new_z >= -OneS))
    else $error("result component out of range");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_if.valid && !res_if.ready) |-> !att_if.ready)
    else $error("input taken while the pipeline is stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (att_if.valid && att_if.ready) |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");
`endif

endmodule
